// ===== sv/rdt_pkg.sv =====
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared types, command codes and defaults for the retriggerable deadman timer.
// ----------------------------------------------------------------------------
package rdt_pkg;

    localparam int TIME_WIDTH_DEFAULT = 48;
    localparam int FIELD_TIME_W       = 48;
    localparam int HORIZON_W          = 32;
    localparam int INC_W              = 16;
    localparam int COUNT_W            = 32;
    localparam int OP_W               = 2;

    localparam logic [HORIZON_W-1:0] HORIZON_RESET = 32'd1000000;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_RING  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [FIELD_TIME_W-1:0] now_ticks;
        logic [INC_W-1:0]        event_increment;
    } rdt_cmd_t;

    typedef struct packed {
        logic                    result_ready;
        logic                    running;
        logic [FIELD_TIME_W-1:0] start_time;
        logic [FIELD_TIME_W-1:0] stop_time;
        logic [COUNT_W-1:0]      total_events;
    } rdt_result_t;

endpackage

// ===== sv/rdt_core.sv =====
// ----------------------------------------------------------------------------
// rdt_core
// Timer state and the combinational command update that produces one result.
// ----------------------------------------------------------------------------
module rdt_core
    import rdt_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  rdt_cmd_t             cmd,
    input  logic [HORIZON_W-1:0] horizon,
    output rdt_result_t          result
);

    localparam int SUM_W = ((TIME_WIDTH > HORIZON_W) ? TIME_WIDTH : HORIZON_W) + 1;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [TIME_WIDTH-1:0] started_reg, started_next;
    logic [TIME_WIDTH-1:0] deadline_reg, deadline_next;
    logic [TIME_WIDTH-1:0] stopped_reg, stopped_next;
    logic [COUNT_W-1:0]    total_reg, total_next;

    logic [TIME_WIDTH-1:0] now_t;
    logic [SUM_W-1:0]      sum;
    logic [TIME_WIDTH-1:0] new_deadline;
    logic                  past;
    logic [COUNT_W:0]      count_sum;
    logic [COUNT_W-1:0]    count_sat;
    logic                  ready;
    logic [63:0]           start_wide;
    logic [63:0]           stop_wide;

    assign now_t        = TIME_WIDTH'(64'(cmd.now_ticks));
    assign sum          = SUM_W'(now_t) + SUM_W'(horizon);
    assign new_deadline = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_WIDTH-1:0];
    assign past         = (now_t >= deadline_reg);
    assign count_sum    = {1'b0, total_reg} + (COUNT_W + 1)'(cmd.event_increment);
    assign count_sat    = count_sum[COUNT_W] ? {COUNT_W{1'b1}} : count_sum[COUNT_W-1:0];
    assign start_wide   = 64'(started_reg);
    assign stop_wide    = 64'(stopped_reg);

    always_comb begin
        active_next   = active_reg;
        done_next     = done_reg;
        started_next  = started_reg;
        deadline_next = deadline_reg;
        stopped_next  = stopped_reg;
        total_next    = total_reg;
        ready         = 1'b0;
        case (cmd.op)
            OP_START: begin
                active_next   = 1'b1;
                done_next     = 1'b0;
                started_next  = now_t;
                deadline_next = new_deadline;
                stopped_next  = now_t;
                total_next    = '0;
            end
            OP_STOP: begin
                if (active_reg) begin
                    stopped_next = now_t;
                    active_next  = 1'b0;
                    done_next    = 1'b1;
                end
            end
            OP_RING: begin
                if (active_reg) begin
                    if (past) begin
                        active_next = 1'b0;
                        done_next   = 1'b1;
                    end else begin
                        stopped_next  = now_t;
                        deadline_next = new_deadline;
                        total_next    = count_sat;
                    end
                end
            end
            OP_READ: begin
                if (active_reg && !done_reg && past) begin
                    active_next = 1'b0;
                    ready       = 1'b1;
                end
                if (done_reg) begin
                    ready = 1'b1;
                end
                done_next = 1'b0;
            end
            default: begin
                active_next = active_reg;
            end
        endcase
    end

    always_comb begin
        result.result_ready = ready;
        result.running      = active_next;
        result.start_time   = ready ? start_wide[FIELD_TIME_W-1:0] : '0;
        result.stop_time    = ready ? stop_wide[FIELD_TIME_W-1:0] : '0;
        result.total_events = ready ? total_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            done_reg     <= 1'b0;
            started_reg  <= '0;
            deadline_reg <= '0;
            stopped_reg  <= '0;
            total_reg    <= '0;
        end else if (fire) begin
            active_reg   <= active_next;
            done_reg     <= done_next;
            started_reg  <= started_next;
            deadline_reg <= deadline_next;
            stopped_reg  <= stopped_next;
            total_reg    <= total_next;
        end
    end

endmodule

// ===== sv/retriggerable_deadman_timer_unit.sv =====
// ----------------------------------------------------------------------------
// retriggerable_deadman_timer_unit
// Retriggerable deadman timer driven by timestamped start, stop, ring and
// read commands; one result beat for every command beat.
//
//   channel | dir | tdata (low bit up)                        | tuser
//   s_      | in  | now_ticks[47:0], event_increment[63:48]   | op[1:0]
//   m_      | out | running[0], start_time[48:1],             | result_ready
//           |     | stop_time[96:49], total_events[128:97]    |
//   cfg_    | in  | horizon_ticks on cfg_wdata when cfg_we    |
//
// One command per cycle while the result channel is not stalled; each command
// passes through the input register, the state update and the result register.
// Reset clears the timer state and loads the default horizon.
// A stalled result register holds the command in the input register, which
// then drops s_tready until the result beat is taken.
// ----------------------------------------------------------------------------
module retriggerable_deadman_timer_unit
    import rdt_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // now_ticks, event_increment
    input  logic [1:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // running, start_time, stop_time, total_events
    output logic         m_tuser    // result_ready
);

    logic                 in_valid_reg;
    rdt_cmd_t             cmd_reg;
    logic                 out_valid_reg;
    rdt_result_t          res_reg;
    rdt_result_t          res_next;
    logic [HORIZON_W-1:0] horizon_reg;
    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            horizon_reg <= HORIZON_RESET;
        end else if (cfg_we) begin
            horizon_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg.op              <= s_tuser;
            cmd_reg.now_ticks       <= s_tdata[47:0];
            cmd_reg.event_increment <= s_tdata[63:48];
        end
    end

    rdt_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .cmd     (cmd_reg),
        .horizon (horizon_reg),
        .result  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.result_ready;
    assign m_tdata  = {7'd0, res_reg.total_events, res_reg.stop_time,
                       res_reg.start_time, res_reg.running};

endmodule
